/* hdl/assert_macros.svh */
// Assertion macros for the shutter channel timer controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/sctc_pkg.sv */
// Shared types and constants of the shutter channel timer controller
package sctc_pkg;
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int TIME_BITS_DEF = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] MASK_ANY = 8'h33;
  localparam logic [7:0] MASK_HI = 8'hCC;

  localparam logic [2:0] REG_BLOCKED = 3'd0;
  localparam logic [2:0] REG_ENABLE = 3'd1;
  localparam logic [2:0] REG_SHORT = 3'd2;
  localparam logic [2:0] REG_LONG = 3'd3;
  localparam logic [2:0] REG_BASE = 3'd4;
  localparam logic [2:0] REG_PAUSE = 3'd5;
  localparam logic [2:0] REG_ENDLESS = 3'd6;
  localparam logic [2:0] REG_PAIRED = 3'd7;

  localparam logic [2:0] ST_EMPTY = 3'd0;
  localparam logic [2:0] ST_UP = 3'd1;
  localparam logic [2:0] ST_DOWN = 3'd2;
  localparam logic [2:0] ST_REV_UP = 3'd5;
  localparam logic [2:0] ST_REV_DOWN = 3'd6;

  typedef struct packed {
    logic       action;
    logic [2:0] command_object;
    logic       direction;
  } item_t;

  typedef struct packed {
    logic [7:0]  blocked_mask;
    logic [7:0]  command_enable_mask;
    logic [31:0] short_factors;
    logic [31:0] long_factors;
    logic [23:0] time_base_codes;
    logic [7:0]  pause_codes;
    logic [3:0]  endless_long_mask;
    logic        paired_mode;
  } cfg_t;

  function automatic logic [9:0] pause_len(input logic [1:0] code);
    case (code)
      2'd0: pause_len = 10'd62;
      2'd1: pause_len = 10'd125;
      2'd2: pause_len = 10'd250;
      default: pause_len = 10'd625;
    endcase
  endfunction

  // factor scaled by time base code, 20 bits wide
  function automatic logic [19:0] scaled(input logic [7:0] f, input logic [2:0] base);
    case (base)
      3'd3: scaled = {8'd0, f, 4'd0};
      3'd4: scaled = {4'd0, f, 8'd0};
      3'd5: scaled = {f, 12'd0};
      default: scaled = {12'd0, f};
    endcase
  endfunction
endpackage

/* hdl/sctc_front.sv */
// Front end: accepts items into a short queue
module sctc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            ready,
  input  sctc_pkg::item_t in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output sctc_pkg::item_t q_item
);
  sctc_pkg::item_t mem [sctc_pkg::QUEUE_DEPTH];
  logic wptr, rptr;
  logic [1:0] count;

  assign ready = count != 2'(sctc_pkg::QUEUE_DEPTH);
  assign q_valid = count != 2'd0;
  assign q_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (valid && ready) mem[wptr] <= in_item;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (valid && ready) wptr <= ~wptr;
      if (q_valid && q_ready) rptr <= ~rptr;
      count <= count + 2'(valid && ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

/* hdl/sctc_back.sv */
// Back end: command execution and sequential walk of the timer records
module sctc_back #(
  parameter int NUM_CHANNELS = sctc_pkg::NUM_CHANNELS_DEF,
  parameter int TIME_BITS = sctc_pkg::TIME_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  sctc_pkg::item_t q_item,
  input  sctc_pkg::cfg_t  cfg,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [7:0]      relay_pattern,
  output logic            boost_pulse,
  output logic            busy
);
  localparam int NREC = 3 * NUM_CHANNELS;
  localparam int RB = $clog2(NREC + 1);
  localparam int CB = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_OUT} state_t;
  state_t state;

  logic [TIME_BITS-1:0] tick_count;
  logic [2:0] rstat [NREC];
  logic [TIME_BITS-1:0] rtgt [NREC];
  logic [7:0] cw [NUM_CHANNELS];
  logic [7:0] last_pattern;
  logic [RB-1:0] ridx;
  // channel of record ridx, stepped alongside it
  logic [CB-1:0] wch;

  // walk step on record ridx
  logic [RB-1:0] wr;
  logic [CB-1:0] wc;
  logic wtravel;
  always_comb begin
    wr = ridx;
    wc = wch;
    wtravel = ridx < RB'(2 * NUM_CHANNELS);
  end

  function automatic logic [TIME_BITS-1:0] pause_tgt(input logic [CB-1:0] c,
      input logic [TIME_BITS-1:0] now, input logic [7:0] codes);
    logic [1:0] code;
    code = codes[2 * (32'(c) & 3) +: 2];
    pause_tgt = now + TIME_BITS'(sctc_pkg::pause_len(code));
  endfunction

  // command decode
  logic [2:0] obj;
  logic [1:0] cc;
  logic [CB-1:0] c;
  logic cmd_ok;
  logic [21:0] ts, tl;
  logic [21:0] tsp, tlp;
  logic [7:0] kin;
  always_comb begin
    obj = q_item.command_object;
    cc = obj[1:0];
    c = CB'(cc);
    cmd_ok = (32'(cc) < NUM_CHANNELS) && !cfg.blocked_mask[obj] &&
             cfg.command_enable_mask[obj];
    ts = 22'(sctc_pkg::scaled(cfg.short_factors[8*cc +: 8],
                              cfg.time_base_codes[6*cc +: 3]));
    tsp = ts + (ts >> 5);
    tl = 22'(sctc_pkg::scaled(cfg.long_factors[8*cc +: 8],
                              cfg.time_base_codes[6*cc+3 +: 3]));
    tl = tl + (tl >> 2);
    tlp = tl + (tl >> 5);
    kin = {4'd0, cw[c][3:0]};
  end

  logic [7:0] pat;
  always_comb begin
    pat = 8'd0;
    for (int k = 0; k < 4; k++) begin
      if ((cfg.paired_mode ? (k & 1) : k) < NUM_CHANNELS)
        pat[2*k +: 2] = cw[CB'(cfg.paired_mode ? (k & 1) : k)][1:0];
    end
  end

  assign q_ready = state == S_IDLE;
  assign res_valid = state == S_OUT;
  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    logic [7:0] kout;
    logic [2:0] tmp;
    logic [2:0] pst;
    logic [TIME_BITS-1:0] pt;
    logic endless;
    kout = 8'd0;
    tmp = 3'd0;
    pst = 3'd0;
    pt = '0;
    endless = 1'b0;
    if (rst) begin
      state <= S_IDLE;
      tick_count <= '0;
      last_pattern <= 8'd0;
      ridx <= '0;
      wch <= '0;
      for (int i = 0; i < NREC; i++) rstat[i] <= sctc_pkg::ST_EMPTY;
      for (int i = 0; i < NUM_CHANNELS; i++) cw[i] <= 8'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (!q_item.action) begin
              tick_count <= tick_count + 1'b1;
              ridx <= '0;
              wch <= '0;
              state <= S_WALK;
            end else begin
              state <= S_OUT;
              if (cmd_ok) begin
                kout = kin;
                pt = pause_tgt(c, tick_count, cfg.pause_codes);
                pst = rstat[2*NUM_CHANNELS + c];
                endless = cfg.endless_long_mask[cc];
                if (!obj[2]) begin
                  if ((kin & sctc_pkg::MASK_ANY) != 0) begin
                    pst = {1'b0, kin[1:0]};
                    rtgt[2*NUM_CHANNELS + c] <= pt;
                    kout = kin & sctc_pkg::MASK_HI;
                    rstat[c] <= sctc_pkg::ST_EMPTY;
                    rstat[NUM_CHANNELS + c] <= sctc_pkg::ST_EMPTY;
                  end else if (cfg.short_factors[8*cc +: 8] != 8'd0) begin
                    if (!q_item.direction) begin
                      kout = (kin | 8'h10) & 8'hDF;
                      rstat[c] <= sctc_pkg::ST_UP;
                      rtgt[c] <= tick_count + TIME_BITS'(tsp);
                    end else begin
                      kout = (kin | 8'h20) & 8'hEF;
                      rstat[c] <= sctc_pkg::ST_DOWN;
                      rtgt[c] <= tick_count + TIME_BITS'(ts);
                    end
                  end
                end else if (!q_item.direction) begin
                  if (kin[0] || kin[4]) rstat[c] <= sctc_pkg::ST_EMPTY;
                  kout = kin | 8'h10;
                  if (kin[1] || kin[5]) begin
                    pst = sctc_pkg::ST_REV_UP;
                    rtgt[2*NUM_CHANNELS + c] <= pt;
                    kout = (kin | 8'h10) & 8'hDF;
                  end
                  if (!endless) begin
                    rstat[NUM_CHANNELS + c] <= sctc_pkg::ST_UP;
                    rtgt[NUM_CHANNELS + c] <= tick_count + TIME_BITS'(tlp);
                  end
                end else begin
                  rstat[c] <= sctc_pkg::ST_EMPTY;
                  kout = kin | 8'h20;
                  if (kin[0] || kin[4]) begin
                    pst = sctc_pkg::ST_REV_DOWN;
                    rtgt[2*NUM_CHANNELS + c] <= pt;
                    kout = (kin | 8'h20) & 8'hEF;
                  end
                  if (!endless) begin
                    rstat[NUM_CHANNELS + c] <= sctc_pkg::ST_DOWN;
                    rtgt[NUM_CHANNELS + c] <= tick_count + TIME_BITS'(tl);
                  end
                end
                tmp = pst;
                if (!tmp[2] && ((tmp[1:0] & kout[5:4]) != 2'd0)) tmp = 3'd0;
                rstat[2*NUM_CHANNELS + c] <= tmp;
                if (tmp[2]) kout = kout & 8'hF0;
                else if (tmp == 3'd0) kout = kout >> 4;
                cw[c] <= kout;
              end
            end
          end
        end
        S_WALK: begin
          if (rstat[wr] != sctc_pkg::ST_EMPTY) begin
            if (rtgt[wr] == tick_count) begin
              rstat[wr] <= sctc_pkg::ST_EMPTY;
              if (wtravel) begin
                cw[wc] <= 8'd0;
                rstat[2*NUM_CHANNELS + wc] <= rstat[wr];
                rtgt[2*NUM_CHANNELS + wc] <= pause_tgt(wc, tick_count, cfg.pause_codes);
              end else begin
                cw[wc] <= cw[wc] >> 4;
              end
            end else if (wtravel && rstat[2*NUM_CHANNELS + wc] != sctc_pkg::ST_EMPTY) begin
              rtgt[wr] <= rtgt[wr] + 1'b1;
            end
          end
          if (ridx == RB'(NREC - 1)) state <= S_OUT;
          ridx <= ridx + 1'b1;
          wch <= (wch == CB'(NUM_CHANNELS - 1)) ? '0 : wch + 1'b1;
        end
        S_OUT: begin
          if (res_ready) begin
            last_pattern <= pat;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign relay_pattern = pat;
  assign boost_pulse = (pat & ~last_pattern) != 8'd0;
endmodule

/* hdl/shutter_channel_timer_controller_unit.sv */
// Top level of the shutter channel timer controller
// Usage:
//  Input channel (valid/ready) carries action, command_object, direction.
//  action 0 is one 8 ms tick, action 1 a command to a step or travel object.
//  Every accepted transaction yields exactly one output transaction with the
//  relay pattern and the boost flag.
//  A two-entry queue sits in front of the executing back end, so the source
//  can hand over up to two transactions while the back end is busy.
//  A command goes from the queue to the back end, which executes it and
//  outputs the result; a tick walks the twelve timer records one per cycle.
//  The back end takes a new transaction only once it has output the last one;
//  a tick is held up by the single record walk in the back end.
//  Configuration registers are written through cfg_we/cfg_index/cfg_data;
//  the user writes them only while the block is idle (the block does not enforce it).
//  Reset (rst, synchronous) clears timers, relay state and the queue.
//  When the receiver holds ready low, the result stays and the back end
//  waits; the queue keeps taking input until it is full.
`include "assert_macros.svh"
module shutter_channel_timer_controller_unit #(
  parameter int NUM_CHANNELS = sctc_pkg::NUM_CHANNELS_DEF,
  parameter int TIME_BITS = sctc_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic        action,
  input  logic [2:0]  command_object,
  input  logic        direction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  relay_pattern,
  output logic        boost_pulse,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  sctc_pkg::cfg_t cfg;
  sctc_pkg::item_t in_item, q_item;
  logic q_valid, q_ready, busy;

  always_comb begin
    in_item.action = action;
    in_item.command_object = command_object;
    in_item.direction = direction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blocked_mask <= 8'd0;
      cfg.command_enable_mask <= 8'hFF;
      cfg.short_factors <= 32'd0;
      cfg.long_factors <= 32'd0;
      cfg.time_base_codes <= 24'd0;
      cfg.pause_codes <= 8'd0;
      cfg.endless_long_mask <= 4'd0;
      cfg.paired_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sctc_pkg::REG_BLOCKED: cfg.blocked_mask <= cfg_data[7:0];
        sctc_pkg::REG_ENABLE: cfg.command_enable_mask <= cfg_data[7:0];
        sctc_pkg::REG_SHORT: cfg.short_factors <= cfg_data;
        sctc_pkg::REG_LONG: cfg.long_factors <= cfg_data;
        sctc_pkg::REG_BASE: cfg.time_base_codes <= cfg_data[23:0];
        sctc_pkg::REG_PAUSE: cfg.pause_codes <= cfg_data[7:0];
        sctc_pkg::REG_ENDLESS: cfg.endless_long_mask <= cfg_data[3:0];
        sctc_pkg::REG_PAIRED: cfg.paired_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sctc_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sctc_back #(.NUM_CHANNELS(NUM_CHANNELS), .TIME_BITS(TIME_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .cfg(cfg), .res_valid(out_valid), .res_ready(out_ready),
    .relay_pattern(relay_pattern), .boost_pulse(boost_pulse), .busy(busy)
  );

  `ASSERT_IMPL(a_take_only_idle, clk, rst, q_valid && q_ready, !busy)
  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(relay_pattern))
  `ASSERT_IMPL(a_boost_has_bit, clk, rst, out_valid && boost_pulse, relay_pattern != 8'h00)
endmodule
